// ===== rtl/ugff_pkg.sv =====
// Shared types, constants and signature tables of the UDP game flood filter.
package ugff_pkg;

    // Drop reason codes carried on the result beat.
    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_EMPTY     = 3'd1,
        RSN_INFO      = 3'd2,
        RSN_NULL      = 3'd3,
        RSN_FLOOD     = 3'd4,
        RSN_DNS_SHORT = 3'd5,
        RSN_DNS_RESP  = 3'd6
    } t_reason;

    // Configuration register indexes.
    typedef enum logic {
        REG_PORT_LOW  = 1'b0,
        REG_PORT_HIGH = 1'b1
    } t_cfg_idx;

    localparam logic [15:0] PORT_LOW_RESET  = 16'd27015;
    localparam logic [15:0] PORT_HIGH_RESET = 16'd27030;

    localparam logic [3:0]  IPV4_VERSION   = 4'd4;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [7:0]  UDP_PROTO      = 8'd17;
    localparam int          PROTO_IDX      = 9;
    localparam int          UDP_HDR_BYTES  = 8;
    localparam int          DPORT_HI_OFF   = 2;
    localparam int          DPORT_LO_OFF   = 3;

    localparam int          INFO_SIG_LEN   = 5;
    localparam int          NULL_SIG_LEN   = 20;
    localparam int          FLOOD_SPAN     = 20;
    localparam logic [7:0]  FLOOD_CHAR     = 8'h20;
    localparam int          FLOOD_MIN_LEN  = 40;

    localparam logic [15:0] DNS_PORT       = 16'd53;
    localparam int          DNS_MIN_LEN    = 12;
    localparam int          DNS_FLAG_OFF   = 2;

    // Per-frame parse state, as seen after the current byte.
    typedef struct packed {
        logic [3:0]  hlw;
        logic        udp_seen;
        logic [15:0] dport;
        logic        info_match;
        logic        null_match;
        logic        flood_match;
        logic        dns_resp;
    } t_frame_info;

    // Info-request signature: FF FF FF FF 6C.
    function automatic logic [7:0] info_sig_byte(input logic [2:0] off);
        logic [7:0] b;
        unique case (off)
            3'd4:    b = 8'h6C;
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    // Null-entity signature: FF FF FF FF 71, fourteen '0', then 00.
    function automatic logic [7:0] null_sig_byte(input logic [4:0] off);
        logic [7:0] b;
        if (off < 5'd4) begin
            b = 8'hFF;
        end else if (off == 5'd4) begin
            b = 8'h71;
        end else if (off == 5'd19) begin
            b = 8'h00;
        end else begin
            b = 8'h30;
        end
        return b;
    endfunction

endpackage

// ===== rtl/ugff_in_if.sv =====
// Input byte channel of the flood filter.
interface ugff_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       ipv4_frame;

    modport source (output valid, output data_byte, output last_byte, output ipv4_frame,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input ipv4_frame,
                    output ready);
endinterface

// ===== rtl/ugff_out_if.sv =====
// Verdict channel of the flood filter.
interface ugff_out_if;
    logic       valid;
    logic       ready;
    logic       drop;
    logic [2:0] drop_reason;

    modport source (output valid, output drop, output drop_reason, input ready);
    modport sink   (input valid, input drop, input drop_reason, output ready);
endinterface

// ===== rtl/udp_game_flood_packet_filter_unit.sv =====
// Top level of the UDP game flood filter: input stage, parser, verdict, result register.
//
// Usage:
//   i_in carries an IP frame one byte per beat, from the first IPv4 header
//   byte on; last_byte marks the final beat, ipv4_frame is the link-layer
//   IPv4 flag and is sampled on that final beat.
//   o_out carries one verdict beat per frame (drop, drop_reason); no beat
//   is produced for non-final bytes.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 = lowest protected port, 1 = highest protected port, inclusive).
//   Write only while no frame is in flight.
// Timing:
//   One byte per cycle while no final byte waits on o_out. A verdict
//   passes two register stages port to port (input register, then
//   parse + verdict logic into the result register).
// Reset:
//   Synchronous, active low. Clears the pipeline and frame state, loads
//   the port range 27015..27030.
// Stall:
//   While a verdict waits on o_out, non-final bytes keep flowing; a final
//   byte waits in the input register, and i_in.ready drops behind it.
module udp_game_flood_packet_filter_unit #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ugff_in_if.sink     i_in,
    ugff_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    // Port range registers
    logic [15:0] r_port_low;
    logic [15:0] r_port_high;

    // Input stage
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_s1_ipv4;

    // Result stage
    logic              r_out_valid;
    ugff_pkg::t_reason r_out_reason;

    logic                  out_free;
    logic                  s1_go;
    logic                  in_take;
    ugff_pkg::t_frame_info info;
    logic [POS_W-1:0]      len;
    ugff_pkg::t_reason     reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_low  <= ugff_pkg::PORT_LOW_RESET;
            r_port_high <= ugff_pkg::PORT_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (ugff_pkg::t_cfg_idx'(i_cfg_index))
                ugff_pkg::REG_PORT_LOW:  r_port_low  <= i_cfg_data;
                ugff_pkg::REG_PORT_HIGH: r_port_high <= i_cfg_data;
                default:                 r_port_low  <= r_port_low;
            endcase
        end
    end

    // A final byte needs a free result slot; other bytes always move on.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
            r_s1_ipv4 <= i_in.ipv4_frame;
        end
    end

    ugff_frame_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .POS_W           (POS_W)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_go),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_info  (info),
        .o_len   (len)
    );

    ugff_verdict #(
        .POS_W (POS_W)
    ) u_verdict (
        .i_info      (info),
        .i_len       (len),
        .i_ipv4      (r_s1_ipv4),
        .i_port_low  (r_port_low),
        .i_port_high (r_port_high),
        .o_reason    (reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_reason <= reason;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drop        = (r_out_reason != ugff_pkg::RSN_NONE);
    assign o_out.drop_reason = r_out_reason;

endmodule

// ===== rtl/ugff_frame_parse.sv =====
// Per-frame byte tracker: header fields, destination port and payload signature flags.
module ugff_frame_parse #(
    parameter int MAX_FRAME_BYTES = 65535,
    parameter int POS_W           = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [7:0]               i_byte,
    input  logic                     i_last,
    output ugff_pkg::t_frame_info    o_info,
    output logic [POS_W-1:0]         o_len
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0]      r_pos;
    ugff_pkg::t_frame_info r_info;
    ugff_pkg::t_frame_info n_info;
    ugff_pkg::t_frame_info clr_info;
    logic [POS_W-1:0]      n_len;
    logic [POS_W-1:0]      hdr;
    logic [POS_W-1:0]      pay;
    logic [POS_W-1:0]      off;

    always_comb begin
        clr_info             = '0;
        clr_info.info_match  = 1'b1;
        clr_info.null_match  = 1'b1;
        clr_info.flood_match = 1'b1;
    end

    assign hdr = POS_W'({r_info.hlw, 2'b00});
    assign pay = hdr + POS_W'(ugff_pkg::UDP_HDR_BYTES);
    assign off = r_pos - pay;

    always_comb begin
        n_info = r_info;
        if (r_pos < MAX_POS) begin
            n_len = r_pos + POS_W'(1);
            if (r_pos == '0) begin
                n_info.hlw      = i_byte[3:0];
                n_info.udp_seen = (i_byte[7:4] == ugff_pkg::IPV4_VERSION) &&
                                  (i_byte[3:0] >= ugff_pkg::MIN_IHL);
            end else begin
                if (r_pos == POS_W'(ugff_pkg::PROTO_IDX)) begin
                    n_info.udp_seen = r_info.udp_seen && (i_byte == ugff_pkg::UDP_PROTO);
                end
                if (r_pos == hdr + POS_W'(ugff_pkg::DPORT_HI_OFF)) begin
                    n_info.dport[15:8] = i_byte;
                end
                if (r_pos == hdr + POS_W'(ugff_pkg::DPORT_LO_OFF)) begin
                    n_info.dport[7:0] = i_byte;
                end
                if (r_pos >= pay) begin
                    if (off < POS_W'(ugff_pkg::INFO_SIG_LEN) &&
                        i_byte != ugff_pkg::info_sig_byte(off[2:0])) begin
                        n_info.info_match = 1'b0;
                    end
                    if (off < POS_W'(ugff_pkg::NULL_SIG_LEN) &&
                        i_byte != ugff_pkg::null_sig_byte(off[4:0])) begin
                        n_info.null_match = 1'b0;
                    end
                    if (off < POS_W'(ugff_pkg::FLOOD_SPAN) && off[0] &&
                        i_byte != ugff_pkg::FLOOD_CHAR) begin
                        n_info.flood_match = 1'b0;
                    end
                    if (off == POS_W'(ugff_pkg::DNS_FLAG_OFF)) begin
                        n_info.dns_resp = i_byte[7];
                    end
                end
            end
        end else begin
            // overlong frame: extra bytes ignored
            n_len = MAX_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_info <= clr_info;
        end else if (i_step) begin
            if (i_last) begin
                r_pos  <= '0;
                r_info <= clr_info;
            end else begin
                r_pos  <= n_len;
                r_info <= n_info;
            end
        end
    end

    assign o_info = n_info;
    assign o_len  = n_len;

endmodule

// ===== rtl/ugff_verdict.sv =====
// Frame verdict from final parse state, frame length and the port range.
module ugff_verdict #(
    parameter int POS_W = 16
) (
    input  ugff_pkg::t_frame_info i_info,
    input  logic [POS_W-1:0]      i_len,
    input  logic                  i_ipv4,
    input  logic [15:0]           i_port_low,
    input  logic [15:0]           i_port_high,
    output ugff_pkg::t_reason     o_reason
);

    logic [POS_W-1:0] pay;
    logic [POS_W-1:0] dlen;
    logic             in_range;

    assign pay      = POS_W'({i_info.hlw, 2'b00}) + POS_W'(ugff_pkg::UDP_HDR_BYTES);
    assign dlen     = i_len - pay;
    assign in_range = (i_info.dport >= i_port_low) && (i_info.dport <= i_port_high);

    always_comb begin
        o_reason = ugff_pkg::RSN_NONE;
        if (i_ipv4 && i_info.udp_seen && (i_len >= pay)) begin
            if (in_range) begin
                priority if (dlen == '0) begin
                    o_reason = ugff_pkg::RSN_EMPTY;
                end else if (dlen >= POS_W'(ugff_pkg::INFO_SIG_LEN) && i_info.info_match) begin
                    o_reason = ugff_pkg::RSN_INFO;
                end else if (dlen >= POS_W'(ugff_pkg::NULL_SIG_LEN) && i_info.null_match) begin
                    o_reason = ugff_pkg::RSN_NULL;
                end else if (dlen > POS_W'(ugff_pkg::FLOOD_MIN_LEN) && i_info.flood_match) begin
                    o_reason = ugff_pkg::RSN_FLOOD;
                end else begin
                    o_reason = ugff_pkg::RSN_NONE;
                end
            end else if (i_info.dport == ugff_pkg::DNS_PORT) begin
                priority if (dlen < POS_W'(ugff_pkg::DNS_MIN_LEN)) begin
                    o_reason = ugff_pkg::RSN_DNS_SHORT;
                end else if (i_info.dns_resp) begin
                    o_reason = ugff_pkg::RSN_DNS_RESP;
                end else begin
                    o_reason = ugff_pkg::RSN_NONE;
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the UDP game flood filter: verdict prediction, stimulus, idle patterns.
`timescale 1ns / 100ps

// Tracks one frame at a time and keeps the verdicts still owed by the block.
class flood_verdict_board;
    typedef struct packed {
        logic              drop;
        ugff_pkg::t_reason reason;
    } t_verdict;

    localparam int unsigned FRAME_CAP = 65535;

    logic [15:0] port_lo;
    logic [15:0] port_hi;

    // per-frame parse state
    logic [15:0] pos;
    logic [3:0]  ihl_words;
    bit          udp_ok;
    logic [15:0] dport;
    bit          info_ok;
    bit          null_ok;
    bit          flood_ok;
    bit          qr_bit;

    t_verdict    verdict_q[$];
    int          errors;
    int          judged;
    int          reason_hits[8];

    function new();
        port_lo = ugff_pkg::PORT_LOW_RESET;
        port_hi = ugff_pkg::PORT_HIGH_RESET;
        restart_frame();
    endfunction

    function void restart_frame();
        pos       = '0;
        ihl_words = '0;
        udp_ok    = 1'b0;
        dport     = '0;
        info_ok   = 1'b1;
        null_ok   = 1'b1;
        flood_ok  = 1'b1;
        qr_bit    = 1'b0;
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    // One accepted beat. A final beat queues the verdict the block owes.
    function void note_byte(logic [7:0] b, logic lst, logic v4);
        int unsigned       idx, len, hdr, pay, off, dlen;
        logic [7:0]        sig;
        ugff_pkg::t_reason why;
        t_verdict          v;
        idx = pos;
        hdr = int'(ihl_words) * 4;
        pay = hdr + ugff_pkg::UDP_HDR_BYTES;
        if (idx < FRAME_CAP) begin
            len = idx + 1;
            if (idx == 0) begin
                ihl_words = b[3:0];
                udp_ok    = (b[7:4] == ugff_pkg::IPV4_VERSION) && (b[3:0] >= ugff_pkg::MIN_IHL);
            end else begin
                if (idx == ugff_pkg::PROTO_IDX)
                    udp_ok = udp_ok && (b == ugff_pkg::UDP_PROTO);
                if (idx == hdr + ugff_pkg::DPORT_HI_OFF)
                    dport[15:8] = b;
                if (idx == hdr + ugff_pkg::DPORT_LO_OFF)
                    dport[7:0] = b;
                if (idx >= pay) begin
                    off = idx - pay;
                    if (off < ugff_pkg::INFO_SIG_LEN) begin
                        sig = (off < 4) ? 8'hFF : 8'h6C;
                        if (b != sig)
                            info_ok = 1'b0;
                    end
                    if (off < ugff_pkg::NULL_SIG_LEN) begin
                        if (off < 4)
                            sig = 8'hFF;
                        else if (off == 4)
                            sig = 8'h71;
                        else if (off == ugff_pkg::NULL_SIG_LEN - 1)
                            sig = 8'h00;
                        else
                            sig = 8'h30;
                        if (b != sig)
                            null_ok = 1'b0;
                    end
                    if (off < ugff_pkg::FLOOD_SPAN && off[0] && b != ugff_pkg::FLOOD_CHAR)
                        flood_ok = 1'b0;
                    if (off == ugff_pkg::DNS_FLAG_OFF)
                        qr_bit = b[7];
                end
            end
        end else begin
            len = FRAME_CAP;
        end
        if (!lst) begin
            pos = len[15:0];
            return;
        end
        // header length may have been set by this very beat
        pay = int'(ihl_words) * 4 + ugff_pkg::UDP_HDR_BYTES;
        why = ugff_pkg::RSN_NONE;
        if (v4 && udp_ok && len >= pay) begin
            dlen = len - pay;
            if (dport >= port_lo && dport <= port_hi) begin
                if (dlen == 0)
                    why = ugff_pkg::RSN_EMPTY;
                else if (dlen >= ugff_pkg::INFO_SIG_LEN && info_ok)
                    why = ugff_pkg::RSN_INFO;
                else if (dlen >= ugff_pkg::NULL_SIG_LEN && null_ok)
                    why = ugff_pkg::RSN_NULL;
                else if (dlen > ugff_pkg::FLOOD_MIN_LEN && flood_ok)
                    why = ugff_pkg::RSN_FLOOD;
            end else if (dport == ugff_pkg::DNS_PORT) begin
                if (dlen < ugff_pkg::DNS_MIN_LEN)
                    why = ugff_pkg::RSN_DNS_SHORT;
                else if (qr_bit)
                    why = ugff_pkg::RSN_DNS_RESP;
            end
        end
        v.drop   = (why != ugff_pkg::RSN_NONE);
        v.reason = why;
        verdict_q.push_back(v);
        restart_frame();
    endfunction

    task report(string msg);
        errors++;
        $display("tb: mismatch: %s", msg);
    endtask

    task check_verdict(logic drop, logic [2:0] reason);
        t_verdict want;
        if (verdict_q.size() == 0) begin
            report($sformatf("verdict drop=%0d reason=%0d with no frame outstanding",
                             drop, reason));
            return;
        end
        want = verdict_q.pop_front();
        judged++;
        reason_hits[want.reason]++;
        if (drop !== want.drop)
            report($sformatf("frame %0d: drop %0d, predicted %0d", judged, drop, want.drop));
        if (reason !== want.reason)
            report($sformatf("frame %0d: reason %0d, predicted %0d",
                             judged, reason, want.reason));
    endtask
endclass

module tb_top;

    typedef logic [7:0] t_byte_q[$];

    // payload shapes the frame builder can produce
    typedef enum int {
        PL_RAND,
        PL_INFO,
        PL_NULL,
        PL_FLOOD,
        PL_DNS_QUERY,
        PL_DNS_RESP
    } t_payload;

    localparam int FRAME_CAP      = 65535;
    localparam int BASE_HDR_BYTES = 20;
    localparam int PHASE_BYTES    = 100;   // 8 phases; about 1850 beats with directed and pressure
    localparam int PRESS_FRAMES   = 6;     // frames offered during the long hold-off
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for the pressure phase
    localparam int QUIET_LIMIT    = 4000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES   = 8;     // extra idle cycles after the last verdict

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    ugff_in_if  in_if();
    ugff_out_if out_if();

    flood_verdict_board board;

    int   tx_idle_pct;
    int   rx_stall_pct;
    logic hold_req;
    bit   hold_done;
    int   hold_left;
    int   quiet;
    int   bytes_sent;
    int   frames_sent;

    udp_game_flood_packet_filter_unit #(
        .MAX_FRAME_BYTES (FRAME_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Verdict side: check every accepted verdict beat, then pick ready for the
    // next edge. A single long hold-off lets the block back up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (out_if.valid && out_if.ready)
                board.check_verdict(out_if.drop, out_if.drop_reason);
            if (hold_req && !hold_done) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: counts edges at which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: timeout after %0d quiet cycles", quiet);
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one beat, with random idle cycles ahead of it, and wait for ready.
    task automatic push_byte(input logic [7:0] b, input logic lst, input logic v4);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.last_byte  <= lst;
        in_if.ipv4_frame <= v4;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        board.note_byte(b, lst, v4);
        bytes_sent++;
    endtask

    // The link-layer flag is held for the whole frame.
    task automatic send_frame(input t_byte_q f, input logic v4);
        for (int i = 0; i < f.size(); i++)
            push_byte(f[i], i == f.size() - 1, v4);
        frames_sent++;
    endtask

    function automatic t_byte_q payload(t_payload kind, int n);
        t_byte_q    p;
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            case (kind)
                PL_INFO: begin
                    if (i < 4)
                        b = 8'hFF;
                    else if (i == 4)
                        b = 8'h6C;
                end
                PL_NULL: begin
                    if (i < 4)
                        b = 8'hFF;
                    else if (i == 4)
                        b = 8'h71;
                    else if (i < 19)
                        b = 8'h30;
                    else if (i == 19)
                        b = 8'h00;
                end
                PL_FLOOD: begin
                    if (i < ugff_pkg::FLOOD_SPAN && (i % 2) == 1)
                        b = ugff_pkg::FLOOD_CHAR;
                end
                PL_DNS_QUERY: begin
                    if (i == ugff_pkg::DNS_FLAG_OFF)
                        b[7] = 1'b0;
                end
                PL_DNS_RESP: begin
                    if (i == ugff_pkg::DNS_FLAG_OFF)
                        b[7] = 1'b1;
                end
                default: ;
            endcase
            p.push_back(b);
        end
        return p;
    endfunction

    // IPv4 + UDP frame. A header length below the minimum still gets a full
    // 20-byte header so the protocol byte sits where it normally would.
    function automatic t_byte_q udp_frame(logic [3:0] ihl, logic [15:0] dp, t_byte_q pl);
        t_byte_q f;
        int      hdr_bytes;
        hdr_bytes = (ihl < ugff_pkg::MIN_IHL) ? BASE_HDR_BYTES : 4 * int'(ihl);
        f.push_back({ugff_pkg::IPV4_VERSION, ihl});
        for (int i = 1; i < hdr_bytes; i++)
            f.push_back((i == ugff_pkg::PROTO_IDX) ? ugff_pkg::UDP_PROTO : 8'($urandom));
        f.push_back(8'($urandom));  // source port
        f.push_back(8'($urandom));
        f.push_back(dp[15:8]);
        f.push_back(dp[7:0]);
        repeat (4) f.push_back(8'($urandom));  // length, checksum
        foreach (pl[i])
            f.push_back(pl[i]);
        return f;
    endfunction

    // Mostly well-formed UDP frames aimed at the protected range, its edges
    // and the DNS port; a share of noise and truncated frames on top.
    task automatic random_frame(output t_byte_q f, output logic v4);
        int          k;
        int          n;
        int          cut;
        int          at;
        logic [3:0]  ihl;
        logic [15:0] dp;
        t_payload    kind;
        t_byte_q     pl;
        v4 = ($urandom_range(19) != 0);
        k  = $urandom_range(99);
        if (k < 8) begin
            // plain noise
            f.delete();
            n = $urandom_range(1, 40);
            repeat (n) f.push_back(8'($urandom));
            return;
        end
        k = $urandom_range(39);
        if (k < 2)
            ihl = 4'($urandom_range(0, 4));
        else if (k < 6)
            ihl = 4'($urandom_range(6, 15));
        else
            ihl = ugff_pkg::MIN_IHL;
        case ($urandom_range(9))
            0, 1, 2, 3: dp = (board.port_lo <= board.port_hi) ?
                             16'($urandom_range(board.port_hi, board.port_lo)) :
                             16'($urandom);
            4:       dp = board.port_lo;
            5:       dp = board.port_hi;
            6:       dp = board.port_lo - 16'd1;
            7:       dp = board.port_hi + 16'd1;
            8:       dp = ugff_pkg::DNS_PORT;
            default: dp = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0:       begin kind = PL_RAND;      n = 0;                     end
            1, 2:    begin kind = PL_INFO;      n = $urandom_range(3, 10);  end
            3:       begin kind = PL_NULL;      n = $urandom_range(18, 24); end
            4, 5:    begin kind = PL_FLOOD;     n = $urandom_range(38, 46); end
            6:       begin kind = PL_DNS_QUERY; n = $urandom_range(9, 14);  end
            7:       begin kind = PL_DNS_RESP;  n = $urandom_range(9, 14);  end
            default: begin kind = PL_RAND;      n = $urandom_range(1, 30);  end
        endcase
        pl = payload(kind, n);
        // spoil one signature byte now and then
        if (kind inside {PL_INFO, PL_NULL, PL_FLOOD} && n > 0 && $urandom_range(3) == 0) begin
            at     = $urandom_range((n < ugff_pkg::FLOOD_SPAN ? n : ugff_pkg::FLOOD_SPAN) - 1);
            pl[at] = pl[at] ^ 8'($urandom_range(1, 255));
        end
        f = udp_frame(ihl, dp, pl);
        if ($urandom_range(24) == 0)
            f[0] = {4'($urandom), f[0][3:0]};
        if ($urandom_range(24) == 0)
            f[ugff_pkg::PROTO_IDX] = 8'($urandom);
        // truncated frame, cut around the end of the UDP header
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, 36);
            while (f.size() > cut)
                void'(f.pop_back());
        end
    endtask

    // Let every owed verdict come back, then give the pipeline time to empty.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Both registers, back to back; write enable stays up across the pair.
    task automatic set_range(input logic [15:0] lo, input logic [15:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ugff_pkg::REG_PORT_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= ugff_pkg::REG_PORT_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.port_lo = lo;
        board.port_hi = hi;
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // Hand-picked frames under the reset port range.
    task automatic run_directed();
        t_byte_q     f;
        logic [15:0] mid;
        logic [15:0] plo;
        logic [15:0] phi;
        plo = ugff_pkg::PORT_LOW_RESET;
        phi = ugff_pkg::PORT_HIGH_RESET;
        mid = plo + 16'd5;
        // empty payload at both range edges, and just outside them
        send_frame(udp_frame(ugff_pkg::MIN_IHL, plo, payload(PL_RAND, 0)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, phi, payload(PL_RAND, 0)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, plo - 16'd1, payload(PL_RAND, 0)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, phi + 16'd1, payload(PL_RAND, 0)), 1'b1);
        // info signature: complete, and one byte short
        send_frame(udp_frame(ugff_pkg::MIN_IHL, mid, payload(PL_INFO, 5)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, mid, payload(PL_INFO, 4)), 1'b1);
        // null entity: complete, and one byte short
        send_frame(udp_frame(ugff_pkg::MIN_IHL, mid, payload(PL_NULL, 20)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, mid, payload(PL_NULL, 19)), 1'b1);
        // flood mark needs more than 40 payload bytes
        send_frame(udp_frame(ugff_pkg::MIN_IHL, mid, payload(PL_FLOOD, 41)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, mid, payload(PL_FLOOD, 40)), 1'b1);
        // DNS: short header, response, query
        send_frame(udp_frame(ugff_pkg::MIN_IHL, ugff_pkg::DNS_PORT,
                             payload(PL_DNS_RESP, 11)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, ugff_pkg::DNS_PORT,
                             payload(PL_DNS_RESP, 12)), 1'b1);
        send_frame(udp_frame(ugff_pkg::MIN_IHL, ugff_pkg::DNS_PORT,
                             payload(PL_DNS_QUERY, 12)), 1'b1);
        // header length below minimum, and the longest header
        send_frame(udp_frame(4'd4, plo, payload(PL_RAND, 0)), 1'b1);
        send_frame(udp_frame(4'd15, plo, payload(PL_RAND, 0)), 1'b1);
        // frame ends inside the UDP header
        f = udp_frame(ugff_pkg::MIN_IHL, plo, payload(PL_RAND, 0));
        void'(f.pop_back());
        send_frame(f, 1'b1);
        // link layer not IPv4
        send_frame(udp_frame(ugff_pkg::MIN_IHL, plo, payload(PL_RAND, 0)), 1'b0);
        // not UDP, then not version 4
        f = udp_frame(ugff_pkg::MIN_IHL, plo, payload(PL_RAND, 0));
        f[ugff_pkg::PROTO_IDX] = 8'd6;
        send_frame(f, 1'b1);
        f = udp_frame(ugff_pkg::MIN_IHL, plo, payload(PL_RAND, 0));
        f[0] = {4'd6, f[0][3:0]};
        send_frame(f, 1'b1);
        // one-beat frame
        f.delete();
        f.push_back({ugff_pkg::IPV4_VERSION, ugff_pkg::MIN_IHL});
        send_frame(f, 1'b1);
        // all ones and all zeros
        f.delete();
        repeat (30) f.push_back(8'hFF);
        send_frame(f, 1'b1);
        f.delete();
        repeat (30) f.push_back(8'h00);
        send_frame(f, 1'b1);
    endtask

    initial begin
        t_byte_q     f;
        logic        v4;
        int          mark;
        logic [15:0] lo;
        logic [15:0] hi;
        board = new();
        bytes_sent  = 0;
        frames_sent = 0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= ugff_pkg::REG_PORT_LOW;
        i_cfg_data       <= '0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= '0;
        in_if.last_byte  <= 1'b0;
        in_if.ipv4_frame <= 1'b0;
        hold_req         <= 1'b0;
        tx_idle_pct      <= 0;
        rx_stall_pct     <= 0;
        quiet            <= 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset range, full rate.
        run_directed();

        // Random traffic. Each phase gets its own port range and idle
        // pattern; registers only change once the block has drained.
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin lo = 16'd0;     hi = 16'hFFFF; end  // every port protected
                1: begin lo = 16'hFFFF;  hi = 16'd0;    end  // empty range
                2: begin                                     // DNS port inside range
                    lo = ugff_pkg::DNS_PORT;
                    hi = ugff_pkg::DNS_PORT;
                end
                3: begin
                    lo = 16'($urandom);
                    hi = lo + 16'($urandom_range(64));
                end
                4: begin lo = 16'd0;     hi = 16'd0;    end
                5: begin lo = 16'hFFFF;  hi = 16'hFFFF; end
                6: begin
                    lo = ugff_pkg::PORT_LOW_RESET;
                    hi = ugff_pkg::PORT_HIGH_RESET;
                end
                default: begin lo = 16'($urandom); hi = 16'($urandom); end
            endcase
            set_range(lo, hi);
            case (ph % 4)
                0: set_idle(0, 0);
                1: set_idle(50, 0);
                2: set_idle(0, 50);
                default: set_idle(11, 11);
            endcase
            mark = bytes_sent;
            while (bytes_sent - mark < PHASE_BYTES) begin
                random_frame(f, v4);
                send_frame(f, v4);
            end
        end

        // Back-pressure: the verdict side holds off for a long stretch while
        // frames keep coming, so the result and input registers both fill.
        settle();
        set_idle(0, 0);
        hold_req <= 1'b1;
        repeat (PRESS_FRAMES) begin
            random_frame(f, v4);
            send_frame(f, v4);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d frames (%0d beats) judged over 9 port ranges and 4 idle patterns",
                 board.judged, bytes_sent);
        $display("tb: drops empty %0d info %0d null %0d flood %0d dns-short %0d dns-resp %0d",
                 board.reason_hits[ugff_pkg::RSN_EMPTY], board.reason_hits[ugff_pkg::RSN_INFO],
                 board.reason_hits[ugff_pkg::RSN_NULL], board.reason_hits[ugff_pkg::RSN_FLOOD],
                 board.reason_hits[ugff_pkg::RSN_DNS_SHORT],
                 board.reason_hits[ugff_pkg::RSN_DNS_RESP]);
        if (board.errors == 0 && board.pending() == 0 && board.judged == frames_sent) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ugff_pkg.sv
rtl/ugff_in_if.sv
rtl/ugff_out_if.sv
rtl/ugff_frame_parse.sv
rtl/ugff_verdict.sv
rtl/udp_game_flood_packet_filter_unit.sv
sim/tb_top.sv
